// ===== rtl/fifo_page_replacement_tracker_core_defines.svh =====
// Assertion macros used by the tracker datapath
`ifndef FIFO_PAGE_REPLACEMENT_TRACKER_CORE_DEFINES_SVH
`define FIFO_PAGE_REPLACEMENT_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FPRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define FPRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fprt_pkg.sv =====
// Package: codes, types and defaults of the page replacement tracker
`timescale 1ns / 1ps
`default_nettype none
package fprt_pkg;

	localparam int TRACKED_ENTRIES_DEF = 64;
	localparam int SWAP_SLOTS_DEF      = 256;

	localparam int OP_W   = 3;
	localparam int PAGE_W = 27;
	localparam int SEQ_W  = 32;
	localparam int OSLT_W = 8;

	localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
	localparam logic [OP_W-1:0] OP_MARK_DIRTY = 3'd1;
	localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd2;
	localparam logic [OP_W-1:0] OP_EVICT      = 3'd3;
	localparam logic [OP_W-1:0] OP_SWAP_IN    = 3'd4;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NONE       = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_SWAP_FULL  = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic idle;
		logic scan;
		logic slot_scan;
		logic apply;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_valid;
		logic scan_done;
		logic need_slot;
		logic slot_done;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/fprt_if.sv =====
// Request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface fprt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [26:0] page_number;
	modport source (output valid, operation, page_number, input ready);
	modport sink (input valid, operation, page_number, output ready);
endinterface

interface fprt_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [26:0] victim_page;
	logic [31:0] victim_sequence;
	logic        victim_was_dirty;
	logic [7:0]  backing_slot;
	modport source (output valid, status, victim_page, victim_sequence, victim_was_dirty,
		backing_slot, input ready);
	modport sink (input valid, status, victim_page, victim_sequence, victim_was_dirty,
		backing_slot, output ready);
endinterface
`default_nettype wire

// ===== rtl/fprt_ctrl.sv =====
// Controller state machine: load, entry sweep, slot sweep, apply
`timescale 1ns / 1ps
`default_nettype none
module fprt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire fprt_pkg::sts_t sts,
	output fprt_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SLOT  = 4'b0100,
		S_APPLY = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		cmd.idle      = 1'b0;
		cmd.scan      = 1'b0;
		cmd.slot_scan = 1'b0;
		cmd.apply     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (sts.req_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = sts.need_slot ? S_SLOT : S_APPLY;
			end
			S_SLOT: begin
				cmd.slot_scan = 1'b1;
				if (sts.slot_done) state_d = S_APPLY;
			end
			S_APPLY: begin
				// hold until the previous result word is taken
				if (!sts.out_busy) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

// ===== rtl/fprt_dp.sv =====
// Datapath: entry tables, flags, swap bitmap, sweeps and result register
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_page_replacement_tracker_core_defines.svh"
module fprt_dp #(
	parameter int TRACKED_ENTRIES = fprt_pkg::TRACKED_ENTRIES_DEF,
	parameter int SWAP_SLOTS      = fprt_pkg::SWAP_SLOTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	fprt_req_if.sink            req,
	fprt_res_if.source          res,
	input  wire fprt_pkg::cmd_t cmd,
	output fprt_pkg::sts_t      sts
);

	localparam int IDX_W  = $clog2(TRACKED_ENTRIES);
	localparam int SLOT_W = $clog2(SWAP_SLOTS);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TRACKED_ENTRIES - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SWAP_SLOTS - 1);

	// tables without reset
	logic [fprt_pkg::PAGE_W-1:0] page_mem [TRACKED_ENTRIES];
	logic [fprt_pkg::SEQ_W-1:0]  seq_mem  [TRACKED_ENTRIES];
	logic [SLOT_W-1:0]           slot_mem [TRACKED_ENTRIES];

	logic [TRACKED_ENTRIES-1:0] valid_q, dirty_q, swapped_q;
	logic [SWAP_SLOTS-1:0]      used_q;
	logic [fprt_pkg::SEQ_W-1:0] counter_q;

	logic [fprt_pkg::OP_W-1:0]   op_q;
	logic [fprt_pkg::PAGE_W-1:0] pg_q;

	logic [IDX_W-1:0] idx_q, idx_s1;
	logic             issued_all_q, rdv_s1, done_q;
	logic [fprt_pkg::PAGE_W-1:0] page_s1;
	logic [fprt_pkg::SEQ_W-1:0]  seq_s1;
	logic [SLOT_W-1:0]           slot_s1;

	logic                        found_q;
	logic [IDX_W-1:0]            best_idx_q;
	logic [fprt_pkg::PAGE_W-1:0] best_page_q;
	logic [fprt_pkg::SEQ_W-1:0]  best_seq_q;
	logic [SLOT_W-1:0]           best_slot_q;

	logic [SLOT_W-1:0] slot_idx_q;
	logic              slot_found_q, slot_done_q;

	logic out_valid_q;
	fprt_pkg::status_t           status_q;
	logic [fprt_pkg::PAGE_W-1:0] vpage_q;
	logic [fprt_pkg::SEQ_W-1:0]  vseq_q;
	logic                        vdirty_q;
	logic [fprt_pkg::OSLT_W-1:0] oslot_q;

	logic load, hit, cand, sel, need_slot, best_dirty;
	logic v_s1, sw_s1;

	fprt_pkg::status_t           a_status;
	logic [fprt_pkg::PAGE_W-1:0] a_vpage;
	logic [fprt_pkg::SEQ_W-1:0]  a_vseq;
	logic                        a_vdirty;
	logic [SLOT_W-1:0]           a_slot;
	logic                        we_reg, we_slot;
	logic [SLOT_W+fprt_pkg::OSLT_W-1:0] slot_ext;

	assign load = cmd.idle && req.valid;
	assign req.ready = cmd.idle;

	assign v_s1  = valid_q[idx_s1];
	assign sw_s1 = swapped_q[idx_s1];
	assign hit   = v_s1 && (page_s1 == pg_q);
	assign cand  = v_s1 && !sw_s1 && (!found_q || (seq_s1 < best_seq_q));

	always_comb begin
		case (op_q) inside
			fprt_pkg::OP_REGISTER: sel = !v_s1 && !found_q;
			fprt_pkg::OP_MARK_DIRTY, fprt_pkg::OP_UNREGISTER: sel = hit && !found_q;
			fprt_pkg::OP_SWAP_IN: sel = hit && sw_s1 && !found_q;
			fprt_pkg::OP_EVICT: sel = cand;
			default: sel = 1'b0;
		endcase
	end

	assign best_dirty = dirty_q[best_idx_q];
	assign need_slot  = (op_q == fprt_pkg::OP_EVICT) && found_q && best_dirty;

	assign sts.req_valid = req.valid;
	assign sts.scan_done = done_q;
	assign sts.need_slot = need_slot;
	assign sts.slot_done = slot_done_q;
	assign sts.out_busy  = out_valid_q && !res.ready;

	// sweep the entry table (issue one read a cycle, judge it in the next cycle) and the swap bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			issued_all_q <= 1'b0;
			rdv_s1       <= 1'b0;
			done_q       <= 1'b0;
			found_q      <= 1'b0;
			slot_idx_q   <= '0;
			slot_found_q <= 1'b0;
			slot_done_q  <= 1'b0;
		end else if (load) begin
			idx_q        <= '0;
			issued_all_q <= 1'b0;
			rdv_s1       <= 1'b0;
			done_q       <= 1'b0;
			found_q      <= 1'b0;
			slot_idx_q   <= '0;
			slot_found_q <= 1'b0;
			slot_done_q  <= 1'b0;
		end else begin
			rdv_s1 <= cmd.scan && !issued_all_q;
			if (cmd.scan && !issued_all_q) begin
				if (idx_q == IDX_LAST) issued_all_q <= 1'b1;
				else idx_q <= idx_q + IDX_W'(1);
			end
			if (rdv_s1) begin
				if (sel) found_q <= 1'b1;
				if (idx_s1 == IDX_LAST) done_q <= 1'b1;
			end
			if (cmd.slot_scan && !slot_done_q) begin
				if (!used_q[slot_idx_q]) begin
					slot_found_q <= 1'b1;
					slot_done_q  <= 1'b1;
				end else if (slot_idx_q == SLOT_LAST) begin
					slot_done_q <= 1'b1;
				end else begin
					slot_idx_q <= slot_idx_q + SLOT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q <= req.operation;
			pg_q <= req.page_number;
		end
		idx_s1 <= idx_q;
		if (rdv_s1 && sel) begin
			best_idx_q  <= idx_s1;
			best_page_q <= page_s1;
			best_seq_q  <= seq_s1;
			best_slot_q <= slot_s1;
		end
	end

	// apply the chosen update
	always_comb begin
		a_status = fprt_pkg::ST_NONE;
		a_vpage  = '0;
		a_vseq   = '0;
		a_vdirty = 1'b0;
		a_slot   = '0;
		we_reg   = 1'b0;
		we_slot  = 1'b0;
		case (op_q) inside
			fprt_pkg::OP_REGISTER: begin
				if (found_q) begin
					a_status = fprt_pkg::ST_OK;
					a_vseq   = counter_q;
					we_reg   = 1'b1;
				end else begin
					a_status = fprt_pkg::ST_TABLE_FULL;
				end
			end
			fprt_pkg::OP_MARK_DIRTY, fprt_pkg::OP_UNREGISTER: begin
				if (found_q) a_status = fprt_pkg::ST_OK;
			end
			fprt_pkg::OP_EVICT: begin
				if (found_q) begin
					if (!best_dirty) begin
						a_status = fprt_pkg::ST_OK;
						a_vpage  = best_page_q;
						a_vseq   = best_seq_q;
					end else if (slot_found_q) begin
						a_status = fprt_pkg::ST_OK;
						a_vpage  = best_page_q;
						a_vseq   = best_seq_q;
						a_vdirty = 1'b1;
						a_slot   = slot_idx_q;
						we_slot  = 1'b1;
					end else begin
						a_status = fprt_pkg::ST_SWAP_FULL;
					end
				end
			end
			fprt_pkg::OP_SWAP_IN: begin
				if (found_q) begin
					a_status = fprt_pkg::ST_OK;
					a_slot   = best_slot_q;
				end
			end
			default: a_status = fprt_pkg::ST_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		page_s1 <= page_mem[idx_q];
		seq_s1  <= seq_mem[idx_q];
		slot_s1 <= slot_mem[idx_q];
		if (cmd.apply && we_reg) begin
			page_mem[best_idx_q] <= pg_q;
			seq_mem[best_idx_q]  <= counter_q;
		end
		if (cmd.apply && (we_reg || we_slot)) slot_mem[best_idx_q] <= a_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			dirty_q   <= '0;
			swapped_q <= '0;
			used_q    <= '0;
			counter_q <= '0;
		end else if (cmd.apply && found_q) begin
			case (op_q)
				fprt_pkg::OP_REGISTER: begin
					valid_q[best_idx_q]   <= 1'b1;
					dirty_q[best_idx_q]   <= 1'b0;
					swapped_q[best_idx_q] <= 1'b0;
					counter_q <= counter_q + {{(fprt_pkg::SEQ_W-1){1'b0}}, 1'b1};
				end
				fprt_pkg::OP_MARK_DIRTY: dirty_q[best_idx_q] <= 1'b1;
				fprt_pkg::OP_UNREGISTER: begin
					valid_q[best_idx_q]   <= 1'b0;
					dirty_q[best_idx_q]   <= 1'b0;
					swapped_q[best_idx_q] <= 1'b0;
				end
				fprt_pkg::OP_EVICT: begin
					if (!best_dirty) begin
						valid_q[best_idx_q] <= 1'b0;
					end else if (slot_found_q) begin
						used_q[slot_idx_q]    <= 1'b1;
						swapped_q[best_idx_q] <= 1'b1;
						dirty_q[best_idx_q]   <= 1'b0;
					end
				end
				fprt_pkg::OP_SWAP_IN: begin
					used_q[best_slot_q]   <= 1'b0;
					valid_q[best_idx_q]   <= 1'b0;
					dirty_q[best_idx_q]   <= 1'b0;
					swapped_q[best_idx_q] <= 1'b0;
				end
				default: counter_q <= counter_q;
			endcase
		end
	end

	// result word register
	assign slot_ext = {{fprt_pkg::OSLT_W{1'b0}}, a_slot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.apply) out_valid_q <= 1'b1;
		else if (res.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			status_q <= a_status;
			vpage_q  <= a_vpage;
			vseq_q   <= a_vseq;
			vdirty_q <= a_vdirty;
			oslot_q  <= slot_ext[fprt_pkg::OSLT_W-1:0];
		end
	end

	assign res.valid            = out_valid_q;
	assign res.status           = status_q;
	assign res.victim_page      = vpage_q;
	assign res.victim_sequence  = vseq_q;
	assign res.victim_was_dirty = vdirty_q;
	assign res.backing_slot     = oslot_q;

	`FPRT_ASSERT_NOW(a_apply_no_overwrite, cmd.apply, !(out_valid_q && !res.ready), "result overwritten")
	`FPRT_ASSERT_NOW(a_one_sweep, cmd.scan, !cmd.slot_scan, "both sweeps active")
	`FPRT_ASSERT_NOW(a_slot_found_done, slot_found_q, slot_done_q, "slot found without done")
	`FPRT_ASSERT_NOW(a_slot_free, cmd.apply && need_slot && slot_found_q, !used_q[slot_idx_q], "slot taken twice")

endmodule
`default_nettype wire

// ===== rtl/fifo_page_replacement_tracker_core.sv =====
// Top level of the FIFO page replacement tracker
// Each request word is loaded, then swept through the entry tables (one read issued a cycle
// over their single read port, judged in the next cycle, and the last judgment registered as
// done); on a dirty eviction the swap bitmap is then swept for its lowest free slot, and the
// update is applied, which holds while the previous result word waits to be taken. The result
// word then sits in an output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module fifo_page_replacement_tracker_core #(
	parameter int TRACKED_ENTRIES = fprt_pkg::TRACKED_ENTRIES_DEF,
	parameter int SWAP_SLOTS      = fprt_pkg::SWAP_SLOTS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	fprt_req_if.sink   req,
	fprt_res_if.source res
);

	fprt_pkg::cmd_t cmd;
	fprt_pkg::sts_t sts;

	fprt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	fprt_dp #(
		.TRACKED_ENTRIES(TRACKED_ENTRIES),
		.SWAP_SLOTS     (SWAP_SLOTS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.res   (res),
		.cmd   (cmd),
		.sts   (sts)
	);

endmodule
`default_nettype wire
